[rtl/kps_pkg.sv]
`default_nettype none

package kps_pkg;

  localparam int unsigned ROWS_W = 4;
  localparam int unsigned COLS_W = 4;
  localparam int unsigned CNT_W  = 3;
  localparam int unsigned IDX_W  = 2;
  localparam int unsigned DEB_W  = 16;
  localparam int unsigned CODE_W = 8;
  localparam int unsigned MAP_W  = 64;
  localparam int unsigned CFG_IDX_W = 3;

  localparam int unsigned DEF_MAX_ROWS = 4;
  localparam int unsigned DEF_MAX_COLS = 4;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_USED   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_USED   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEYMAP_LOW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEYMAP_HIGH = 3'd4;

  localparam logic [CNT_W-1:0] RESET_ROWS_USED = 3'd4;
  localparam logic [CNT_W-1:0] RESET_COLS_USED = 3'd4;
  localparam logic [DEB_W-1:0] RESET_DEBOUNCE  = 16'd20;

  typedef struct packed {
    logic [ROWS_W-1:0] row_drive;
    logic              key_valid;
    logic [CODE_W-1:0] key_code;
    logic [IDX_W-1:0]  key_row;
    logic [IDX_W-1:0]  key_col;
  } kps_result_t;

endpackage

`default_nettype wire

[rtl/kps_core.sv]
`default_nettype none

module kps_core import kps_pkg::*; #(
  parameter int unsigned MAX_ROWS = DEF_MAX_ROWS,
  parameter int unsigned MAX_COLS = DEF_MAX_COLS
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [MAP_W-1:0]     cfg_data,
  input  wire logic                 step,
  input  wire logic [COLS_W-1:0]    column_levels,
  output kps_result_t               result
);

  localparam logic [1:0] PH_RELEASE  = 2'd0;
  localparam logic [1:0] PH_PRESS    = 2'd1;
  localparam logic [1:0] PH_DEBOUNCE = 2'd2;
  localparam logic [1:0] PH_SCAN     = 2'd3;

  localparam logic [CNT_W-1:0] MAX_ROWS_C = CNT_W'(MAX_ROWS);
  localparam logic [CNT_W-1:0] MAX_COLS_C = CNT_W'(MAX_COLS);

  logic [CNT_W-1:0] rows_used_r;
  logic [CNT_W-1:0] cols_used_r;
  logic [DEB_W-1:0] debounce_ticks_r;
  logic [MAP_W-1:0] keymap_low_r;
  logic [MAP_W-1:0] keymap_high_r;

  logic [1:0]       phase_r, phase_nxt;
  logic [IDX_W-1:0] scan_row_r, scan_row_nxt;
  logic [DEB_W-1:0] debounce_count_r, debounce_count_nxt;

  logic [CNT_W-1:0] rows, cols;
  logic [IDX_W-1:0] col;
  logic             any_low;
  logic [IDX_W-1:0] row_inc;
  logic [DEB_W-1:0] count_inc;
  logic [4:0]       idx_full;
  logic [3:0]       idx;
  logic [MAP_W-1:0] map_word;
  logic [MAP_W-1:0] map_shifted;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_used_r      <= RESET_ROWS_USED;
      cols_used_r      <= RESET_COLS_USED;
      debounce_ticks_r <= RESET_DEBOUNCE;
      keymap_low_r     <= '0;
      keymap_high_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROWS_USED:   rows_used_r      <= cfg_data[CNT_W-1:0];
        REG_COLS_USED:   cols_used_r      <= cfg_data[CNT_W-1:0];
        REG_DEBOUNCE:    debounce_ticks_r <= cfg_data[DEB_W-1:0];
        REG_KEYMAP_LOW:  keymap_low_r     <= cfg_data;
        REG_KEYMAP_HIGH: keymap_high_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (rows_used_r == '0) rows = CNT_W'(1);
    else if (rows_used_r > MAX_ROWS_C) rows = MAX_ROWS_C;
    else rows = rows_used_r;
    if (cols_used_r == '0) cols = CNT_W'(1);
    else if (cols_used_r > MAX_COLS_C) cols = MAX_COLS_C;
    else cols = cols_used_r;
  end

  // lowest pulled-low column among the wired ones
  always_comb begin
    col     = '0;
    any_low = 1'b0;
    for (int c = COLS_W - 1; c >= 0; c--) begin
      if ((CNT_W'(c) < cols) && !column_levels[c]) begin
        col     = IDX_W'(c);
        any_low = 1'b1;
      end
    end
  end

  assign row_inc     = scan_row_r + IDX_W'(1);
  assign count_inc   = debounce_count_r + DEB_W'(1);
  assign idx_full    = (5'(cols) * 5'(scan_row_r)) + 5'(col);
  assign idx         = idx_full[3:0];
  assign map_word    = idx[3] ? keymap_high_r : keymap_low_r;
  assign map_shifted = map_word >> {idx[2:0], 3'b000};

  always_comb begin
    phase_nxt          = phase_r;
    scan_row_nxt       = scan_row_r;
    debounce_count_nxt = debounce_count_r;
    result             = '0;
    case (phase_r)
      PH_RELEASE: begin
        if (!any_low) phase_nxt = PH_PRESS;
      end
      PH_PRESS: begin
        if (any_low) begin
          debounce_count_nxt = '0;
          if (debounce_ticks_r == '0) begin
            phase_nxt    = PH_SCAN;
            scan_row_nxt = '0;
          end else begin
            phase_nxt = PH_DEBOUNCE;
          end
        end
      end
      PH_DEBOUNCE: begin
        debounce_count_nxt = count_inc;
        if (count_inc >= debounce_ticks_r) begin
          if (any_low) begin
            phase_nxt    = PH_SCAN;
            scan_row_nxt = '0;
          end else begin
            phase_nxt = PH_PRESS;
          end
        end
      end
      default: begin
        if ((CNT_W'(scan_row_r) < rows) && any_low) begin
          result.key_valid = 1'b1;
          result.key_code  = map_shifted[CODE_W-1:0];
          result.key_row   = scan_row_r;
          result.key_col   = col;
        end
        scan_row_nxt = row_inc;
        // past the last wired row: go back to waiting for release
        if ((row_inc == '0) || (CNT_W'(row_inc) >= rows)) begin
          phase_nxt    = PH_RELEASE;
          scan_row_nxt = '0;
        end
      end
    endcase

    result.row_drive = '1;
    for (int r = 0; r < ROWS_W; r++) begin
      if ((CNT_W'(r) < rows) &&
          ((phase_nxt != PH_SCAN) || (IDX_W'(r) == scan_row_nxt)))
        result.row_drive[r] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= PH_RELEASE;
      scan_row_r       <= '0;
      debounce_count_r <= '0;
    end else if (step) begin
      phase_r          <= phase_nxt;
      scan_row_r       <= scan_row_nxt;
      debounce_count_r <= debounce_count_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/matrix_keypad_scanner.sv]
`default_nettype none

// Matrix keypad scanner with debounce.
// Input channel: one request per tick carrying the column levels sampled under
// the row drive of the previous result (in_valid / in_stall). Each accepted
// request yields exactly one result on the output channel: the row drive for
// the next tick, plus a key report (valid, code, row, column) during the scan.
// Configuration: cfg_valid / cfg_ready write register cfg_index with cfg_data;
// cfg_ready is always high. Write only while the block is idle.
// An accepted result is registered in the output register, or in the skid entry
// while the output waits. Throughput: one request per cycle while in_stall is
// low; the whole step (column search, keymap byte select, phase update) sits
// between the input port and the output register.
// Stalls: an output register plus one skid entry; in_stall rises only once the
// skid entry holds a result, so a request is still taken while the output
// waits. Nothing is lost or repeated under stall.
// Reset (rst_n low, synchronous): output and skid empty, phase is waiting for
// release, registers take their defaults (4 rows, 4 columns, 20 ticks,
// keymaps zero).
module matrix_keypad_scanner import kps_pkg::*; #(
  parameter int unsigned MAX_ROWS = DEF_MAX_ROWS,
  parameter int unsigned MAX_COLS = DEF_MAX_COLS
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [COLS_W-1:0]    in_column_levels,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [ROWS_W-1:0]         out_row_drive,
  output logic                      out_key_valid,
  output logic [CODE_W-1:0]         out_key_code,
  output logic [IDX_W-1:0]          out_key_row,
  output logic [IDX_W-1:0]          out_key_col,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [MAP_W-1:0]     cfg_data
);

  logic        in_fire, out_fire;
  kps_result_t step_result;
  kps_result_t out_r, skid_r;
  logic        out_valid_r, skid_valid_r;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid_r;
  assign in_fire   = in_valid && !in_stall;
  assign out_fire  = out_valid_r && !out_stall;

  kps_core #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .step          (in_fire),
    .column_levels (in_column_levels),
    .result        (step_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (!out_valid_r || out_fire) begin
        // refill from skid first, else from the new request
        if (skid_valid_r) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end else begin
          out_valid_r <= in_fire;
        end
      end else if (in_fire) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_fire) begin
      if (skid_valid_r) out_r <= skid_r;
      else if (in_fire) out_r <= step_result;
    end
    if (in_fire && out_valid_r && !out_fire) skid_r <= step_result;
  end

  assign out_valid     = out_valid_r;
  assign out_row_drive = out_r.row_drive;
  assign out_key_valid = out_r.key_valid;
  assign out_key_code  = out_r.key_code;
  assign out_key_row   = out_r.key_row;
  assign out_key_col   = out_r.key_col;

endmodule

`default_nettype wire

[verif/tb_matrix_keypad_scanner.sv]
`timescale 1ns / 1ps

module tb_matrix_keypad_scanner;
  import kps_pkg::*;

  localparam int HOLD_OFF_CYCLES = 400;
  localparam int STALL_LIMIT     = 2000;
  localparam int MAX_PRINTED     = 100;

  typedef enum logic [1:0] {
    PH_WAIT_RELEASE,
    PH_WAIT_PRESS,
    PH_DEBOUNCE,
    PH_SCAN
  } scan_phase_e;

  class keypad_scoreboard;
    logic [CNT_W-1:0]  rows_reg;
    logic [CNT_W-1:0]  cols_reg;
    logic [DEB_W-1:0]  deb_reg;
    logic [MAP_W-1:0]  map_lo;
    logic [MAP_W-1:0]  map_hi;
    scan_phase_e       phase;
    logic [IDX_W-1:0]  scan_row;
    logic [DEB_W-1:0]  deb_count;
    logic [ROWS_W-1:0] row_drive;
    kps_result_t       expected_q[$];
    int                errors;

    function new();
      rows_reg  = RESET_ROWS_USED;
      cols_reg  = RESET_COLS_USED;
      deb_reg   = RESET_DEBOUNCE;
      map_lo    = '0;
      map_hi    = '0;
      phase     = PH_WAIT_RELEASE;
      scan_row  = '0;
      deb_count = '0;
      row_drive = '0;
      errors    = 0;
    endfunction

    function int clamp_count(logic [CNT_W-1:0] v, int max);
      if (int'(v) < 1) return 1;
      if (int'(v) > max) return max;
      return int'(v);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [MAP_W-1:0] data);
      case (idx)
        REG_ROWS_USED:   rows_reg = data[CNT_W-1:0];
        REG_COLS_USED:   cols_reg = data[CNT_W-1:0];
        REG_DEBOUNCE:    deb_reg = data[DEB_W-1:0];
        REG_KEYMAP_LOW:  map_lo = data;
        REG_KEYMAP_HIGH: map_hi = data;
        default: ;
      endcase
    endfunction

    // One scan tick: advance the phase and form the result for these levels.
    function kps_result_t scan_tick(logic [COLS_W-1:0] levels);
      int rows, cols, col, idx, c;
      bit any_low;
      logic [MAP_W-1:0] word;
      kps_result_t res;
      rows = clamp_count(rows_reg, DEF_MAX_ROWS);
      cols = clamp_count(cols_reg, DEF_MAX_COLS);
      col = cols;
      for (c = cols - 1; c >= 0; c--)
        if (!levels[c]) col = c;
      any_low = (col < cols);
      res = '0;
      case (phase)
        PH_WAIT_RELEASE: if (!any_low) phase = PH_WAIT_PRESS;
        PH_WAIT_PRESS: begin
          if (any_low) begin
            deb_count = '0;
            if (deb_reg == 0) begin
              phase = PH_SCAN;
              scan_row = '0;
            end else begin
              phase = PH_DEBOUNCE;
            end
          end
        end
        PH_DEBOUNCE: begin
          deb_count = deb_count + 1'b1;
          if (deb_count >= deb_reg) begin
            if (any_low) begin
              phase = PH_SCAN;
              scan_row = '0;
            end else begin
              phase = PH_WAIT_PRESS;
            end
          end
        end
        PH_SCAN: begin
          if (int'(scan_row) < rows && any_low) begin
            idx = (cols * int'(scan_row) + col) % 16;
            word = (idx < 8) ? map_lo : map_hi;
            res.key_valid = 1'b1;
            res.key_code = word[(idx % 8) * 8 +: CODE_W];
            res.key_row = scan_row;
            res.key_col = IDX_W'(col);
          end
          scan_row = scan_row + 1'b1;
          if (scan_row == 0 || int'(scan_row) >= rows) begin
            phase = PH_WAIT_RELEASE;
            scan_row = '0;
          end
        end
        default: ;
      endcase
      res.row_drive = '1;
      for (c = 0; c < rows; c++)
        if (phase != PH_SCAN || int'(scan_row) == c) res.row_drive[c] = 1'b0;
      row_drive = res.row_drive;
      return res;
    endfunction

    function void note_request(logic [COLS_W-1:0] levels);
      expected_q.push_back(scan_tick(levels));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report(string msg);
      // keep a broken block from flooding the log
      if (errors < MAX_PRINTED) $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(kps_result_t got);
      kps_result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result %h", got));
        return;
      end
      want = expected_q.pop_front();
      if (got.row_drive !== want.row_drive)
        report($sformatf("row_drive got %h want %h", got.row_drive, want.row_drive));
      if (got.key_valid !== want.key_valid)
        report($sformatf("key_valid got %b want %b", got.key_valid, want.key_valid));
      if (got.key_code !== want.key_code)
        report($sformatf("key_code got %h want %h", got.key_code, want.key_code));
      if (got.key_row !== want.key_row)
        report($sformatf("key_row got %0d want %0d", got.key_row, want.key_row));
      if (got.key_col !== want.key_col)
        report($sformatf("key_col got %0d want %0d", got.key_col, want.key_col));
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [COLS_W-1:0]    in_column_levels = '1;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [ROWS_W-1:0]    out_row_drive;
  logic                 out_key_valid;
  logic [CODE_W-1:0]    out_key_code;
  logic [IDX_W-1:0]     out_key_row;
  logic [IDX_W-1:0]     out_key_col;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [MAP_W-1:0]     cfg_data = '0;

  keypad_scoreboard sb = new();

  int          cur_rows = 4;
  int          cur_cols = 4;
  int          cur_deb = 20;
  bit          steady = 1'b0;
  bit          hold_req = 1'b0;
  logic [15:0] keys_down = '0;
  int          key_hold = 0;
  int          idle_cycles = 0;

  matrix_keypad_scanner u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_column_levels (in_column_levels),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_row_drive    (out_row_drive),
    .out_key_valid    (out_key_valid),
    .out_key_code     (out_key_code),
    .out_key_row      (out_key_row),
    .out_key_col      (out_key_col),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Random upper bits above a register's width
  function automatic logic [MAP_W-1:0] padded(logic [MAP_W-1:0] v, int w);
    logic [MAP_W-1:0] mask;
    mask = (64'd1 << w) - 1;
    return ({$urandom, $urandom} & ~mask) | (v & mask);
  endfunction

  // Column levels seen under the current row drive with these keys held down
  function automatic logic [COLS_W-1:0] keypad_levels(logic [15:0] pressed);
    logic [COLS_W-1:0] lv;
    int r, c;
    lv = '1;
    for (r = 0; r < 4; r++)
      for (c = 0; c < 4; c++)
        if (!sb.row_drive[r] && pressed[r * 4 + c]) lv[c] = 1'b0;
    // unwired columns float
    for (c = cur_cols; c < COLS_W; c++) lv[c] = 1'($urandom_range(0, 1));
    return lv;
  endfunction

  function automatic logic [15:0] pick_keys();
    int r;
    logic [15:0] m;
    r = $urandom_range(0, 99);
    m = '0;
    if (r < 60)
      m[$urandom_range(0, cur_rows - 1) * 4 + $urandom_range(0, cur_cols - 1)] = 1'b1;
    else if (r < 75)
      m[$urandom_range(0, 15)] = 1'b1;
    else
      m = 16'($urandom);
    if (m == 0) m[0] = 1'b1;
    return m;
  endfunction

  task automatic send_request(logic [COLS_W-1:0] lv);
    int gap;
    in_valid <= 1'b1;
    in_column_levels <= lv;
    do @(posedge clk); while (in_stall);
    sb.note_request(lv);
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [MAP_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_regs(int rows, int cols, int deb,
                              logic [MAP_W-1:0] lo, logic [MAP_W-1:0] hi);
    write_reg(REG_ROWS_USED, padded(64'(rows), CNT_W));
    write_reg(REG_COLS_USED, padded(64'(cols), CNT_W));
    write_reg(REG_DEBOUNCE, padded(64'(deb), DEB_W));
    write_reg(REG_KEYMAP_LOW, lo);
    write_reg(REG_KEYMAP_HIGH, hi);
    cfg_valid <= 1'b0;
    cur_rows = sb.clamp_count(sb.rows_reg, DEF_MAX_ROWS);
    cur_cols = sb.clamp_count(sb.cols_reg, DEF_MAX_COLS);
    cur_deb = int'(sb.deb_reg);
  endtask

  task automatic hold_keys(logic [15:0] pressed, int ticks);
    repeat (ticks) send_request(keypad_levels(pressed));
  endtask

  // Press and release sessions, with bounces and some raw noise
  task automatic run_keys(int n, int noise_pct);
    logic [COLS_W-1:0] lv;
    repeat (n) begin
      if (key_hold == 0) begin
        if (keys_down != 0 || $urandom_range(0, 3) == 0) begin
          keys_down = '0;
          key_hold = $urandom_range(1, 4);
        end else begin
          keys_down = pick_keys();
          if ($urandom_range(0, 4) == 0)
            key_hold = $urandom_range(1, cur_deb + 1);
          else
            key_hold = cur_deb + cur_rows + $urandom_range(2, 6);
        end
      end
      key_hold--;
      if ($urandom_range(0, 99) < noise_pct)
        lv = COLS_W'($urandom);
      else
        lv = keypad_levels(keys_down);
      send_request(lv);
    end
  endtask

  task automatic run_phase(int rows, int cols, int deb, logic [MAP_W-1:0] lo,
                           logic [MAP_W-1:0] hi, int n, int noise_pct,
                           bit calm, bit hold_off);
    wait_idle();
    program_regs(rows, cols, deb, lo, hi);
    // cut a long press short so it still holds into the new setting
    if (key_hold > 50) key_hold = 3;
    steady = calm;
    run_keys(n / 3, noise_pct);
    wait_idle();
    if (hold_off) hold_req = 1'b1;
    run_keys(n - n / 3, noise_pct);
    steady = 1'b0;
  endtask

  initial begin : result_sink
    int stall_left;
    kps_result_t got;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got = {out_row_drive, out_key_valid, out_key_code, out_key_row, out_key_col};
        sb.check_result(got);
      end
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = HOLD_OFF_CYCLES;
      end else if (stall_left == 0 && !steady && $urandom_range(0, 99) < 30) begin
        stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(1, 3);
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("tb_matrix_keypad_scanner: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: released keypad
    hold_keys(16'h0000, 3);
    wait_idle();

    program_regs(4, 4, 0, 64'h0706_0504_0302_01FF, 64'h000E_0D0C_0B0A_0908);
    hold_keys(16'h0000, 2);
    hold_keys(16'h0001, 5);   // top-left key
    hold_keys(16'h0000, 1);
    hold_keys(16'h8000, 5);   // bottom-right key
    hold_keys(16'h0000, 1);
    hold_keys(16'h0600, 5);   // two keys in one row, lowest column wins
    hold_keys(16'h0000, 1);
    hold_keys(16'hFFFF, 5);   // every key down

    run_phase(4, 4, 3, {$urandom, $urandom}, {$urandom, $urandom}, 250, 10, 1'b0, 1'b1);
    run_phase(1, 1, 0, '1, '0, 150, 10, 1'b0, 1'b0);
    run_phase(0, 7, 1, {$urandom, $urandom}, {$urandom, $urandom}, 120, 10, 1'b0, 1'b0);
    run_phase(5, 0, 2, '0, '1, 120, 40, 1'b0, 1'b0);
    run_phase(2, 3, 65535, {$urandom, $urandom}, {$urandom, $urandom}, 80, 5, 1'b0, 1'b0);
    // lowered debounce ends the running count at once
    run_phase(3, 2, 4, {$urandom, $urandom}, {$urandom, $urandom}, 200, 10, 1'b1, 1'b1);
    repeat (5)
      run_phase($urandom_range(1, 4), $urandom_range(1, 4), $urandom_range(0, 6),
                {$urandom, $urandom}, {$urandom, $urandom}, 75, 10,
                1'($urandom_range(0, 1)), 1'b0);

    wait_idle();
    if (sb.errors == 0 && sb.pending() == 0)
      $display("tb_matrix_keypad_scanner: done, clean");
    else
      $display("tb_matrix_keypad_scanner: done, errors");
    $finish;
  end

endmodule
